[rtl/core/tplu_pkg.sv]
// Shared types, codes and constants for the two-level page table unit.
package tplu_pkg;

   // Default geometry: directory and table index widths.
   localparam int DIR_INDEX_BITS_DEFAULT   = 10;
   localparam int TABLE_INDEX_BITS_DEFAULT = 10;

   // Address bit positions of the two indexes.
   localparam int DIR_SHIFT = 22;
   localparam int TBL_SHIFT = 12;

   // Opcodes.
   localparam logic [2:0] OP_TRANSLATE = 3'd0;
   localparam logic [2:0] OP_RESOLVE   = 3'd1;
   localparam logic [2:0] OP_MAP       = 3'd2;
   localparam logic [2:0] OP_UNMAP     = 3'd3;
   localparam logic [2:0] OP_EDIT      = 3'd4;

   // Entry bits and masks.
   localparam int         BIT_PRESENT = 0;
   localparam int         BIT_HUGE    = 7;
   localparam logic [31:0] F_PRESENT   = 32'h0000_0001;
   localparam logic [31:0] F_WRITE     = 32'h0000_0002;
   localparam logic [31:0] F_USER      = 32'h0000_0004;
   localparam logic [31:0] MASK_4K     = 32'hFFFF_F000;
   localparam logic [31:0] MASK_4M     = 32'hFFC0_0000;
   localparam logic [31:0] FAULT_VALUE = 32'hFFFF_FFFF;

   localparam logic [31:0] KERNEL_SPLIT_RESET = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_CLEAR_DIR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CLEAR_TBL,
      ST_WRITE_TBL,
      ST_RESP
   } state_type;

   // How the entry unit forms its result.
   typedef enum logic [1:0] {
      ALU_RAW,
      ALU_4K,
      ALU_4M
   } alu_mode_type;

endpackage

[rtl/core/tplu_entry_alu.sv]
// Shared entry unit: masks an entry to its frame and adds the page offset, or passes it raw.
module tplu_entry_alu (
   input  logic                  [31:0] entry_value,
   input  logic                  [31:0] address,
   input  tplu_pkg::alu_mode_type       mode,
   output logic                  [31:0] result
);

   logic [31:0] base;
   logic [31:0] offset;

   always_comb begin
      case (mode)
         tplu_pkg::ALU_4K: begin
            base   = entry_value & tplu_pkg::MASK_4K;
            offset = address & ~tplu_pkg::MASK_4K;
         end
         tplu_pkg::ALU_4M: begin
            base   = entry_value & tplu_pkg::MASK_4M;
            offset = address & ~tplu_pkg::MASK_4M;
         end
         default: begin
            base   = entry_value;
            offset = 32'd0;
         end
      endcase
   end

   // single adder, shared by both page sizes
   assign result = base + offset;

endmodule

[rtl/core/two_level_page_table_unit_core.sv]
// Top level of the two-level page table unit: sequencer, directory and table memories.
// After reset a clearing pass zeroes the directory; no item is taken until it is done.
// An accepted item passes the read, evaluate and response states; the next item is taken
// the cycle after the result goes out, which the output side can stall.
// Map adds a table write state, plus a clearing pass over the table block when it
// creates a directory entry. The table memory has no reset.
module two_level_page_table_unit_core #(
   parameter int DIR_INDEX_BITS   = tplu_pkg::DIR_INDEX_BITS_DEFAULT,
   parameter int TABLE_INDEX_BITS = tplu_pkg::TABLE_INDEX_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_virtual_address,
   input  logic [31:0] req_physical_address,
   input  logic [11:0] req_entry_flags,
   input  logic [31:0] req_new_table_frame,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   output logic        rsp_success
);

   localparam int DIR_COUNT = 1 << DIR_INDEX_BITS;
   localparam int SLOT_BITS = DIR_INDEX_BITS + TABLE_INDEX_BITS;
   localparam int SLOT_COUNT = 1 << SLOT_BITS;

   // --- state ---
   tplu_pkg::state_type state_ff, state_in;

   logic [31:0] kernel_split_ff;

   // latched item
   logic [2:0]  op_ff;
   logic [31:0] va_ff;
   logic [31:0] pa_ff;
   logic [11:0] fl_ff;
   logic [31:0] frame_ff;

   // sweep counters
   logic [DIR_INDEX_BITS-1:0]   dir_clr_ff;
   logic [TABLE_INDEX_BITS-1:0] tbl_clr_ff;

   // memories and their registered read data
   logic [31:0] dir_mem [DIR_COUNT];
   logic [31:0] tbl_mem [SLOT_COUNT];
   logic [31:0] dir_rd_ff;
   logic [31:0] tbl_rd_ff;

   // result register
   logic [31:0] rsp_value_ff;
   logic        rsp_ok_ff;

   // --- decode ---
   logic                        req_accept;
   logic [DIR_INDEX_BITS-1:0]   dir_idx;
   logic [TABLE_INDEX_BITS-1:0] tbl_idx;
   logic [SLOT_BITS-1:0]        slot;
   logic                        pd_present;
   logic                        pd_huge;
   logic                        pt_present;
   logic                        is_walk;

   assign req_accept = req_valid && !req_stall;
   assign dir_idx    = va_ff[tplu_pkg::DIR_SHIFT +: DIR_INDEX_BITS];
   assign tbl_idx    = va_ff[tplu_pkg::TBL_SHIFT +: TABLE_INDEX_BITS];
   assign slot       = {dir_idx, tbl_idx};
   assign pd_present = dir_rd_ff[tplu_pkg::BIT_PRESENT];
   assign pd_huge    = dir_rd_ff[tplu_pkg::BIT_HUGE];
   assign pt_present = tbl_rd_ff[tplu_pkg::BIT_PRESENT];
   assign is_walk    = (op_ff == tplu_pkg::OP_TRANSLATE) || (op_ff == tplu_pkg::OP_RESOLVE);

   // --- shared entry unit ---
   tplu_pkg::alu_mode_type alu_mode;
   logic [31:0]            alu_entry;
   logic [31:0]            alu_result;

   // huge directory entry answers on its own; else the table entry
   assign alu_entry = pd_huge ? dir_rd_ff : tbl_rd_ff;

   always_comb begin
      if (op_ff == tplu_pkg::OP_RESOLVE) begin
         alu_mode = tplu_pkg::ALU_RAW;
      end else if (pd_huge) begin
         alu_mode = tplu_pkg::ALU_4M;
      end else begin
         alu_mode = tplu_pkg::ALU_4K;
      end
   end

   tplu_entry_alu u_entry_alu (
      .entry_value (alu_entry),
      .address     (va_ff),
      .mode        (alu_mode),
      .result      (alu_result)
   );

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tplu_pkg::ST_CLEAR_DIR: begin
            if (&dir_clr_ff) state_in = tplu_pkg::ST_IDLE;
         end
         tplu_pkg::ST_IDLE: begin
            if (req_accept) state_in = tplu_pkg::ST_READ;
         end
         tplu_pkg::ST_READ: begin
            state_in = tplu_pkg::ST_EVAL;
         end
         tplu_pkg::ST_EVAL: begin
            if (op_ff == tplu_pkg::OP_MAP) begin
               state_in = pd_present ? tplu_pkg::ST_WRITE_TBL : tplu_pkg::ST_CLEAR_TBL;
            end else begin
               state_in = tplu_pkg::ST_RESP;
            end
         end
         tplu_pkg::ST_CLEAR_TBL: begin
            if (&tbl_clr_ff) state_in = tplu_pkg::ST_WRITE_TBL;
         end
         tplu_pkg::ST_WRITE_TBL: begin
            state_in = tplu_pkg::ST_RESP;
         end
         tplu_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = tplu_pkg::ST_IDLE;
         end
         default: begin
            state_in = tplu_pkg::ST_CLEAR_DIR;
         end
      endcase
   end

   // --- outputs of the sequencer ---
   logic                      dir_we;
   logic [DIR_INDEX_BITS-1:0] dir_waddr;
   logic [31:0]               dir_wdata;
   logic                      tbl_we;
   logic [SLOT_BITS-1:0]      tbl_waddr;
   logic [31:0]               tbl_wdata;
   logic                      res_load;
   logic [31:0]               res_value;
   logic                      res_ok;
   logic [31:0]               new_dir_flags;

   // fresh directory entry: present, writeable, user below the split
   assign new_dir_flags = tplu_pkg::F_WRITE | tplu_pkg::F_PRESENT |
                          ((va_ff < kernel_split_ff) ? tplu_pkg::F_USER : 32'd0);

   always_comb begin
      dir_we    = 1'b0;
      dir_waddr = dir_idx;
      dir_wdata = (frame_ff & tplu_pkg::MASK_4K) | new_dir_flags;
      tbl_we    = 1'b0;
      tbl_waddr = slot;
      tbl_wdata = 32'd0;
      res_load  = 1'b0;
      res_value = 32'd0;
      res_ok    = 1'b0;
      case (state_ff)
         tplu_pkg::ST_CLEAR_DIR: begin
            dir_we    = 1'b1;
            dir_waddr = dir_clr_ff;
            dir_wdata = 32'd0;
         end
         tplu_pkg::ST_EVAL: begin
            res_load = 1'b1;
            if (is_walk) begin
               if (!pd_present || (!pd_huge && !pt_present)) begin
                  res_value = tplu_pkg::FAULT_VALUE;
               end else begin
                  res_value = alu_result;
                  res_ok    = 1'b1;
               end
            end else begin
               case (op_ff)
                  tplu_pkg::OP_MAP: begin
                     res_ok = 1'b1;
                     dir_we = !pd_present;
                  end
                  tplu_pkg::OP_UNMAP: begin
                     res_ok = 1'b1;
                     tbl_we = pd_present;
                  end
                  tplu_pkg::OP_EDIT: begin
                     res_ok    = pd_present && pt_present;
                     tbl_we    = pd_present && pt_present;
                     tbl_wdata = (tbl_rd_ff & tplu_pkg::MASK_4K) | {20'd0, fl_ff} |
                                 tplu_pkg::F_PRESENT;
                  end
                  default: begin
                     res_ok = 1'b0;
                  end
               endcase
            end
         end
         tplu_pkg::ST_CLEAR_TBL: begin
            tbl_we    = 1'b1;
            tbl_waddr = {dir_idx, tbl_clr_ff};
         end
         tplu_pkg::ST_WRITE_TBL: begin
            tbl_we    = 1'b1;
            tbl_wdata = pa_ff | {20'd0, fl_ff};
         end
         default: begin
            res_load = 1'b0;
         end
      endcase
   end

   // --- control registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tplu_pkg::ST_CLEAR_DIR;
         kernel_split_ff <= tplu_pkg::KERNEL_SPLIT_RESET;
         dir_clr_ff      <= '0;
         tbl_clr_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) kernel_split_ff <= csr_write_data;
         if (state_ff == tplu_pkg::ST_CLEAR_DIR) dir_clr_ff <= dir_clr_ff + 1'b1;
         // wraps back to zero at the end of each block sweep
         if (state_ff == tplu_pkg::ST_CLEAR_TBL) tbl_clr_ff <= tbl_clr_ff + 1'b1;
      end
   end

   // --- payload registers ---
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_opcode;
         va_ff    <= req_virtual_address;
         pa_ff    <= req_physical_address;
         fl_ff    <= req_entry_flags;
         frame_ff <= req_new_table_frame;
      end
      if (res_load) begin
         rsp_value_ff <= res_value;
         rsp_ok_ff    <= res_ok;
      end
   end

   // --- directory memory ---
   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
   end

   always_ff @(posedge clock) begin
      dir_rd_ff <= dir_mem[dir_idx];
   end

   // --- table memory; both indexes come straight from the address ---
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
   end

   always_ff @(posedge clock) begin
      tbl_rd_ff <= tbl_mem[slot];
   end

   // --- ports ---
   assign req_stall        = (state_ff != tplu_pkg::ST_IDLE);
   assign rsp_valid        = (state_ff == tplu_pkg::ST_RESP);
   assign rsp_result_value = rsp_value_ff;
   assign rsp_success      = rsp_ok_ff;

endmodule

[tb/sv/tb_two_level_page_table_unit_core.sv]
// Self-checking testbench for the two-level page table unit: directed and random items.
`timescale 1ns / 100ps

module tb_two_level_page_table_unit_core;
   import tplu_pkg::*;

   // Cycles without any accepted item before the run is declared hung. The limit
   // outlasts a table block clear and the directory clear after reset.
   localparam int STUCK_LIMIT = 20000;
   localparam int TBL_ENTRIES = 1 << TABLE_INDEX_BITS_DEFAULT;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 258;

   // One result item as the block should return it.
   typedef struct {
      logic [31:0] value;
      logic        ok;
   } walk_result_t;

   // Shadow copy of the directory and tables; predicts one result per request.
   class page_walk_scoreboard;
      logic [31:0]  dir_mem [TBL_ENTRIES];
      logic [31:0]  tbl_mem [bit [19:0]];
      logic [31:0]  split;
      walk_result_t pending_results[$];
      int           error_count;

      function new();
         foreach (dir_mem[i]) dir_mem[i] = '0;
         split       = KERNEL_SPLIT_RESET;
         error_count = 0;
      endfunction

      function void set_split(logic [31:0] value);
         split = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function logic [31:0] read_tbl(bit [19:0] slot);
         return tbl_mem.exists(slot) ? tbl_mem[slot] : '0;
      endfunction

      function void apply_request(logic [2:0] op, logic [31:0] va, logic [31:0] pa,
                                  logic [11:0] fl, logic [31:0] frame);
         logic [9:0]   di;
         bit [19:0]    slot;
         logic [31:0]  pd;
         logic [31:0]  pt;
         logic [31:0]  dir_flags;
         walk_result_t res;
         di        = va[31:DIR_SHIFT];
         slot      = va[31:TBL_SHIFT];
         pd        = dir_mem[di];
         res.value = '0;
         res.ok    = 1'b0;
         case (op)
            OP_TRANSLATE, OP_RESOLVE: begin
               if (!pd[BIT_PRESENT]) begin
                  res.value = FAULT_VALUE;
               end else if (pd[BIT_HUGE]) begin
                  res.value = (op == OP_TRANSLATE) ? (pd & MASK_4M) + {10'd0, va[21:0]} : pd;
                  res.ok    = 1'b1;
               end else begin
                  pt = read_tbl(slot);
                  if (!pt[BIT_PRESENT]) begin
                     res.value = FAULT_VALUE;
                  end else begin
                     res.value = (op == OP_TRANSLATE) ? (pt & MASK_4K) + {20'd0, va[11:0]}
                                                      : pt;
                     res.ok    = 1'b1;
                  end
               end
            end
            OP_MAP: begin
               if (!pd[BIT_PRESENT]) begin
                  dir_flags = F_WRITE | F_PRESENT;
                  if (va < split) dir_flags |= F_USER;
                  dir_mem[di] = (frame & MASK_4K) | dir_flags;
                  for (int i = 0; i < TBL_ENTRIES; i++) tbl_mem[{di, i[9:0]}] = '0;
               end
               tbl_mem[slot] = pa | {20'd0, fl};
               res.ok        = 1'b1;
            end
            OP_UNMAP: begin
               if (pd[BIT_PRESENT]) tbl_mem[slot] = '0;
               res.ok = 1'b1;
            end
            OP_EDIT: begin
               pt = read_tbl(slot);
               if (pd[BIT_PRESENT] && pt[BIT_PRESENT]) begin
                  tbl_mem[slot] = (pt & MASK_4K) | {20'd0, fl} | F_PRESENT;
                  res.ok        = 1'b1;
               end
            end
            default: ;
         endcase
         pending_results.push_back(res);
      endfunction

      function void check_result(logic [31:0] value, logic ok);
         walk_result_t exp_res;
         if (pending_results.size() == 0) begin
            $error("result item with nothing pending: result_value %h success %b", value, ok);
            error_count++;
            return;
         end
         exp_res = pending_results.pop_front();
         if (value !== exp_res.value) begin
            $error("result_value expected %h actual %h", exp_res.value, value);
            error_count++;
         end
         if (ok !== exp_res.ok) begin
            $error("success expected %b actual %b", exp_res.ok, ok);
            error_count++;
         end
      endfunction
   endclass

   // DUT ports; every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = OP_TRANSLATE;
   logic [31:0] req_virtual_address = '0;
   logic [31:0] req_physical_address = '0;
   logic [11:0] req_entry_flags = '0;
   logic [31:0] req_new_table_frame = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_value;
   logic        rsp_success;

   page_walk_scoreboard sb = new();

   // Idle percentages of the current phase, per cycle.
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   // Address pools keep most random items on a few directory slots and table
   // slots, so maps, walks, edits and unmaps hit the same entries.
   logic [9:0]  dir_pool [8];
   logic [9:0]  tbl_pool [6];
   logic [31:0] last_va = '0;
   logic [31:0] phase_split [PHASE_COUNT];
   int          phase_send [PHASE_COUNT] = '{0, 52, 0, 21, 0, 21};
   int          phase_stall [PHASE_COUNT] = '{0, 0, 52, 21, 0, 21};

   two_level_page_table_unit_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_virtual_address  (req_virtual_address),
      .req_physical_address (req_physical_address),
      .req_entry_flags      (req_entry_flags),
      .req_new_table_frame  (req_new_table_frame),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_value     (rsp_result_value),
      .rsp_success          (rsp_success)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side: check what was accepted at this edge (old stall value),
   // then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_result_value, rsp_success);
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Hang detector: any accepted item on either channel restarts the count.
   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
      end
      $display("tb_two_level_page_table_unit_core: errors");
      $finish;
   end

   // Present one request item and hold it until accepted; the prediction is
   // made at the accepting edge. Valid is left high so the next item can
   // follow back to back.
   task automatic send_req(input logic [2:0] op, input logic [31:0] va,
                           input logic [31:0] pa, input logic [11:0] fl,
                           input logic [31:0] frame);
      if (send_idle_pct != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid            <= 1'b1;
      req_opcode           <= op;
      req_virtual_address  <= va;
      req_physical_address <= pa;
      req_entry_flags      <= fl;
      req_new_table_frame  <= frame;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.apply_request(op, va, pa, fl, frame);
   endtask

   // Register write; only called with nothing in flight.
   task automatic write_split(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      sb.set_split(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait for every expected result, then let the clock run on so the block is idle.
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly map / walk / edit / unmap on pooled addresses, with a share of
   // address reuse, fully random addresses and unknown opcodes.
   task automatic send_random_item();
      logic [2:0]  op;
      logic [9:0]  di;
      logic [9:0]  ti;
      logic [31:0] va;
      logic [31:0] pa;
      logic [31:0] frame;
      logic [11:0] fl;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) op = OP_MAP;
      else if (pick < 55) op = OP_TRANSLATE;
      else if (pick < 70) op = OP_RESOLVE;
      else if (pick < 80) op = OP_UNMAP;
      else if (pick < 95) op = OP_EDIT;
      else op = 3'($urandom_range(7, 5));
      if ($urandom_range(99) < 30) begin
         va = last_va;
      end else begin
         // new directory slots are rare: each one costs a table block clear
         di = ($urandom_range(99) < 5) ? 10'($urandom) : dir_pool[$urandom_range(7)];
         ti = ($urandom_range(99) < 70) ? tbl_pool[$urandom_range(5)] : 10'($urandom);
         va = {di, ti, 12'($urandom)};
      end
      pa = $urandom;
      fl = 12'($urandom);
      if (op == OP_MAP && $urandom_range(99) < 80) fl[BIT_PRESENT] = 1'b1;
      frame = $urandom;
      if ($urandom_range(99) < 70) frame[11:0] = '0;
      last_va = va;
      send_req(op, va, pa, fl, frame);
   endtask

   initial begin : main
      dir_pool = '{10'd0, 10'd1023, 10'd511, 10'd512, 10'($urandom), 10'($urandom),
                   10'($urandom), 10'($urandom)};
      tbl_pool = '{10'd0, 10'd1023, 10'd1, 10'($urandom), 10'($urandom), 10'($urandom)};
      phase_split = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom,
                      32'h0000_0001};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // register holds its reset value, but write it anyway
      write_split(KERNEL_SPLIT_RESET);

      // Directed: walks, edit and unmap on an empty directory; the walks fault.
      send_req(OP_TRANSLATE, 32'h0000_0000, '0, '0, '0);
      send_req(OP_RESOLVE, 32'hFFFF_FFFF, '0, '0, '0);
      send_req(OP_EDIT, 32'h1234_5678, '0, 12'hFFF, '0);
      send_req(OP_UNMAP, 32'h1234_5678, '0, '0, '0);
      // map below the split with an unaligned table frame
      send_req(OP_MAP, 32'h0000_0ABC, 32'hFFFF_F000, 12'h003, 32'h0001_2345);
      send_req(OP_TRANSLATE, 32'h0000_0ABC, '0, '0, '0);
      send_req(OP_RESOLVE, 32'h0000_0000, '0, '0, '0);
      // neighbor slot of a fresh block reads back cleared
      send_req(OP_TRANSLATE, 32'h0000_1000, '0, '0, '0);
      send_req(OP_EDIT, 32'h0000_0000, '0, 12'h000, '0);
      send_req(OP_RESOLVE, 32'h0000_0000, '0, '0, '0);
      // all ones everywhere, above the split: translation equals fault value
      send_req(OP_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
      send_req(OP_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0);
      send_req(OP_RESOLVE, 32'hFFC0_0000, '0, '0, '0);
      // non-present table entry in a present directory slot
      send_req(OP_MAP, 32'hFFC0_0000, 32'h0000_0000, 12'h000, 32'h0000_0000);
      send_req(OP_TRANSLATE, 32'hFFC0_0000, '0, '0, '0);
      send_req(OP_EDIT, 32'hFFC0_0000, '0, 12'hFFF, '0);
      send_req(OP_UNMAP, 32'hFFFF_FFFF, '0, '0, '0);
      send_req(OP_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0);
      // either side of the split
      send_req(OP_MAP, 32'h7FFF_F000, 32'h1234_5000, 12'h001, 32'h0040_0000);
      send_req(OP_MAP, 32'h8000_0000, 32'h8765_4000, 12'h007, 32'h0080_0000);
      send_req(OP_TRANSLATE, 32'h8000_0123, '0, '0, '0);
      send_req(OP_TRANSLATE, 32'h7FFF_FFFF, '0, '0, '0);
      // unknown opcodes
      send_req(3'd5, $urandom, $urandom, 12'($urandom), $urandom);
      send_req(3'd6, $urandom, $urandom, 12'($urandom), $urandom);
      send_req(3'd7, $urandom, $urandom, 12'($urandom), $urandom);
      req_valid <= 1'b0;

      // Random phases, each setting its split and idle pattern.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         write_split(phase_split[p]);
         send_idle_pct = phase_send[p];
         stall_pct     = phase_stall[p];
         repeat (PHASE_ITEMS) send_random_item();
         req_valid <= 1'b0;
      end

      wait_drained();
      if (sb.error_count == 0) begin
         $display("tb_two_level_page_table_unit_core: clean");
      end else begin
         $display("tb_two_level_page_table_unit_core: errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/tplu_pkg.sv
rtl/core/tplu_entry_alu.sv
rtl/core/two_level_page_table_unit_core.sv
tb/sv/tb_two_level_page_table_unit_core.sv
